// ----- rtl/core/lsdp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsdp_pkg: shared types and constants for the sector direction picker
// Field widths, register indexes, direction codes and the window helper.
// ----------------------------------------------------------------------------
package lsdp_pkg;

  localparam int RANGE_BITS     = 16;
  localparam int INDEX_BITS     = 12;
  localparam int MAX_HALF_WIDTH = 255;

  localparam int THR_BITS      = 16;
  localparam int CENTRE_BITS   = 12;
  localparam int HW_BITS       = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int DIR_BITS      = 2;

  // a window holds at most 2*MAX_HALF_WIDTH samples
  localparam int SUM_BITS = RANGE_BITS + $clog2(2 * MAX_HALF_WIDTH + 1);
  localparam int LEN_BITS = INDEX_BITS + 1;
  localparam int CMP_BITS = ((CENTRE_BITS > LEN_BITS) ? CENTRE_BITS : LEN_BITS) + 1;

  localparam int NUM_SECTORS = 3;
  localparam int SEC_FRONT   = 0;
  localparam int SEC_RIGHT   = 1;
  localparam int SEC_LEFT    = 2;

  localparam logic [THR_BITS-1:0]    RST_FRONT_THR    = THR_BITS'(400);
  localparam logic [THR_BITS-1:0]    RST_SIDE_THR     = THR_BITS'(300);
  localparam logic [THR_BITS-1:0]    RST_MIN_VALID    = THR_BITS'(0);
  localparam logic [CENTRE_BITS-1:0] RST_FRONT_CENTRE = CENTRE_BITS'(360);
  localparam logic [CENTRE_BITS-1:0] RST_LEFT_CENTRE  = CENTRE_BITS'(480);
  localparam logic [CENTRE_BITS-1:0] RST_RIGHT_CENTRE = CENTRE_BITS'(240);
  localparam logic [HW_BITS-1:0]     RST_HALF_WIDTH   = HW_BITS'(60);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRONT_THR    = 3'd0,
    CFG_SIDE_THR     = 3'd1,
    CFG_MIN_VALID    = 3'd2,
    CFG_FRONT_CENTRE = 3'd3,
    CFG_LEFT_CENTRE  = 3'd4,
    CFG_RIGHT_CENTRE = 3'd5,
    CFG_HALF_WIDTH   = 3'd6
  } cfg_reg_t;

  typedef enum logic [DIR_BITS-1:0] {
    DIR_FORWARD = 2'd0,
    DIR_LEFT    = 2'd1,
    DIR_RIGHT   = 2'd2,
    DIR_ERROR   = 2'd3
  } dir_t;

  typedef logic [SUM_BITS-1:0] sum_t;

  // end-of-scan snapshot handed to the decision stage
  typedef struct packed {
    sum_t [NUM_SECTORS-1:0]  sums;
    logic [NUM_SECTORS-1:0]  hits;
    logic [LEN_BITS-1:0]     len;
  } scan_snap_t;

  // index lies in [centre - hw, centre + hw); empty if window starts below 0
  function automatic logic in_window(input logic [INDEX_BITS-1:0]  idx,
                                     input logic [CENTRE_BITS-1:0] centre,
                                     input logic [HW_BITS-1:0]     hw);
    logic [CMP_BITS-1:0] c;
    logic [CMP_BITS-1:0] h;
    logic [CMP_BITS-1:0] i;
    c = CMP_BITS'(centre);
    h = CMP_BITS'(hw);
    i = CMP_BITS'(idx);
    return (c >= h) && (i >= c - h) && (i < c + h);
  endfunction

endpackage

// ----- rtl/core/lsdp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsdp_if: valid/ready channels of the sector direction picker
// Sample input, direction result and register write channels.
// ----------------------------------------------------------------------------
interface lsdp_in_if;
  logic                            valid;
  logic                            ready;
  logic [lsdp_pkg::RANGE_BITS-1:0] range_mm;
  logic                            last_sample;

  modport source (output valid, output range_mm, output last_sample, input ready);
  modport sink   (input valid, input range_mm, input last_sample, output ready);
endinterface

interface lsdp_out_if;
  logic                          valid;
  logic                          ready;
  logic [lsdp_pkg::DIR_BITS-1:0] direction;

  modport source (output valid, output direction, input ready);
  modport sink   (input valid, input direction, output ready);
endinterface

interface lsdp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lsdp_pkg::CFG_IDX_BITS-1:0]  reg_index;
  logic [lsdp_pkg::CFG_DATA_BITS-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- rtl/core/lidar_sector_direction_picker_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_sector_direction_picker_top: picks a travel direction from one scan
//
// in_chan takes one range sample per request, in scan order; last_sample
// closes the scan. Front, right and left windows each keep a range sum and
// a collision flag. One direction request leaves on out_chan per scan:
// forward, left, right, or error when a window starts below 0 or ends past the scan.
// cfg_chan writes the seven registers; it is always ready and is meant to
// be used only while no scan result is outstanding.
// Throughput: one sample per cycle while in_chan is ready, set by the window
// compare and sum add on the accumulator registers.
// The edge that takes the last sample loads the decision stage snapshot;
// the direction is then loaded into the output register, which raises
// out_chan valid, as soon as that register is free or being read.
// Reset (rst_n low, synchronous) restores register defaults and clears the
// scan state and both result stages.
// When out_chan stalls, its direction holds in the output register, one
// more finished scan can wait in the decision stage and samples keep
// flowing; in_chan drops ready while both result stages are full.
// ----------------------------------------------------------------------------
module lidar_sector_direction_picker_top (
  input  logic       clk,
  input  logic       rst_n,
  lsdp_in_if.sink    in_chan,
  lsdp_out_if.source out_chan,
  lsdp_cfg_if.sink   cfg_chan
);

  localparam int NS = lsdp_pkg::NUM_SECTORS;
  localparam logic [lsdp_pkg::LEN_BITS-1:0] FULL_LEN =
    lsdp_pkg::LEN_BITS'(1) << lsdp_pkg::INDEX_BITS;

  // ---------------- configuration registers ----------------
  logic [lsdp_pkg::THR_BITS-1:0]    front_thr_r;
  logic [lsdp_pkg::THR_BITS-1:0]    side_thr_r;
  logic [lsdp_pkg::THR_BITS-1:0]    min_valid_r;
  logic [lsdp_pkg::CENTRE_BITS-1:0] front_centre_r;
  logic [lsdp_pkg::CENTRE_BITS-1:0] left_centre_r;
  logic [lsdp_pkg::CENTRE_BITS-1:0] right_centre_r;
  logic [lsdp_pkg::HW_BITS-1:0]     half_width_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_thr_r    <= lsdp_pkg::RST_FRONT_THR;
      side_thr_r     <= lsdp_pkg::RST_SIDE_THR;
      min_valid_r    <= lsdp_pkg::RST_MIN_VALID;
      front_centre_r <= lsdp_pkg::RST_FRONT_CENTRE;
      left_centre_r  <= lsdp_pkg::RST_LEFT_CENTRE;
      right_centre_r <= lsdp_pkg::RST_RIGHT_CENTRE;
      half_width_r   <= lsdp_pkg::RST_HALF_WIDTH;
    end else if (cfg_chan.valid) begin
      case (lsdp_pkg::cfg_reg_t'(cfg_chan.reg_index))
        lsdp_pkg::CFG_FRONT_THR:    front_thr_r    <= cfg_chan.wdata[lsdp_pkg::THR_BITS-1:0];
        lsdp_pkg::CFG_SIDE_THR:     side_thr_r     <= cfg_chan.wdata[lsdp_pkg::THR_BITS-1:0];
        lsdp_pkg::CFG_MIN_VALID:    min_valid_r    <= cfg_chan.wdata[lsdp_pkg::THR_BITS-1:0];
        lsdp_pkg::CFG_FRONT_CENTRE: front_centre_r <= cfg_chan.wdata[lsdp_pkg::CENTRE_BITS-1:0];
        lsdp_pkg::CFG_LEFT_CENTRE:  left_centre_r  <= cfg_chan.wdata[lsdp_pkg::CENTRE_BITS-1:0];
        lsdp_pkg::CFG_RIGHT_CENTRE: right_centre_r <= cfg_chan.wdata[lsdp_pkg::CENTRE_BITS-1:0];
        lsdp_pkg::CFG_HALF_WIDTH:   half_width_r   <= cfg_chan.wdata[lsdp_pkg::HW_BITS-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // saturated half width
  logic [lsdp_pkg::HW_BITS-1:0] hw_eff;
  assign hw_eff = (int'(half_width_r) > lsdp_pkg::MAX_HALF_WIDTH) ?
                  lsdp_pkg::HW_BITS'(lsdp_pkg::MAX_HALF_WIDTH) : half_width_r;

  // per-sector views, indexed like the hit flags
  logic [lsdp_pkg::CENTRE_BITS-1:0] centre [NS];
  logic [lsdp_pkg::THR_BITS-1:0]    thr    [NS];
  always_comb begin
    centre[lsdp_pkg::SEC_FRONT] = front_centre_r;
    centre[lsdp_pkg::SEC_RIGHT] = right_centre_r;
    centre[lsdp_pkg::SEC_LEFT]  = left_centre_r;
    thr[lsdp_pkg::SEC_FRONT]    = front_thr_r;
    thr[lsdp_pkg::SEC_RIGHT]    = side_thr_r;
    thr[lsdp_pkg::SEC_LEFT]     = side_thr_r;
  end

  // ---------------- handshake ----------------
  logic pend_v_r, pend_v_nxt;
  logic out_v_r, out_v_nxt;
  logic out_adv, pend_adv, in_acc, last_acc;

  assign out_adv  = !out_v_r || out_chan.ready;
  assign pend_adv = pend_v_r && out_adv;
  assign in_chan.ready = !pend_v_r || out_adv;
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign last_acc = in_acc && in_chan.last_sample;

  // ---------------- accumulator stage ----------------
  logic [lsdp_pkg::INDEX_BITS-1:0] idx_r, idx_nxt, idx_upd;
  logic                            ovf_r, ovf_nxt, ovf_upd;
  lsdp_pkg::sum_t [NS-1:0]         sum_r, sum_nxt, sum_upd;
  logic [NS-1:0]                   hit_r, hit_nxt, hit_upd;
  logic [lsdp_pkg::INDEX_BITS:0]   idx_inc;
  logic [lsdp_pkg::LEN_BITS-1:0]   len_upd;
  logic                            range_ok;
  logic                            win;

  always_comb begin
    idx_inc  = {1'b0, idx_r} + (lsdp_pkg::INDEX_BITS + 1)'(1);
    range_ok = in_chan.range_mm > min_valid_r;
    sum_upd  = sum_r;
    hit_upd  = hit_r;
    idx_upd  = idx_r;
    ovf_upd  = ovf_r;
    win      = 1'b0;
    // once the index wraps, further samples are ignored
    if (!ovf_r) begin
      for (int s = 0; s < NS; s++) begin
        win = lsdp_pkg::in_window(idx_r, centre[s], hw_eff);
        if (win) begin
          sum_upd[s] = sum_r[s] + lsdp_pkg::SUM_BITS'(in_chan.range_mm);
          if (range_ok && (in_chan.range_mm < thr[s])) begin
            hit_upd[s] = 1'b1;
          end
        end
      end
      idx_upd = idx_inc[lsdp_pkg::INDEX_BITS] ? '0 : idx_inc[lsdp_pkg::INDEX_BITS-1:0];
      ovf_upd = idx_inc[lsdp_pkg::INDEX_BITS];
    end
    len_upd = ovf_upd ? FULL_LEN : lsdp_pkg::LEN_BITS'(idx_upd);

    sum_nxt = sum_r;
    hit_nxt = hit_r;
    idx_nxt = idx_r;
    ovf_nxt = ovf_r;
    if (last_acc) begin
      sum_nxt = '0;
      hit_nxt = '0;
      idx_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (in_acc) begin
      sum_nxt = sum_upd;
      hit_nxt = hit_upd;
      idx_nxt = idx_upd;
      ovf_nxt = ovf_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      hit_r <= '0;
      idx_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      hit_r <= hit_nxt;
      idx_r <= idx_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // ---------------- decision stage ----------------
  lsdp_pkg::scan_snap_t snap_r;

  assign pend_v_nxt = last_acc ? 1'b1 : (pend_adv ? 1'b0 : pend_v_r);

  always_ff @(posedge clk) begin
    if (last_acc) begin
      snap_r.sums <= sum_upd;
      snap_r.hits <= hit_upd;
      snap_r.len  <= len_upd;
    end
  end

  lsdp_pkg::dir_t dir;
  logic           covered;
  logic [lsdp_pkg::CMP_BITS-1:0] c_w, h_w, l_w;
  lsdp_pkg::sum_t fs, rs, ls;
  logic           fh, rh, lh;

  always_comb begin
    covered = 1'b1;
    h_w     = lsdp_pkg::CMP_BITS'(hw_eff);
    l_w     = lsdp_pkg::CMP_BITS'(snap_r.len);
    c_w     = '0;
    for (int s = 0; s < NS; s++) begin
      c_w = lsdp_pkg::CMP_BITS'(centre[s]);
      if ((c_w < h_w) || (c_w + h_w > l_w)) begin
        covered = 1'b0;
      end
    end
    fs = snap_r.sums[lsdp_pkg::SEC_FRONT];
    rs = snap_r.sums[lsdp_pkg::SEC_RIGHT];
    ls = snap_r.sums[lsdp_pkg::SEC_LEFT];
    fh = snap_r.hits[lsdp_pkg::SEC_FRONT];
    rh = snap_r.hits[lsdp_pkg::SEC_RIGHT];
    lh = snap_r.hits[lsdp_pkg::SEC_LEFT];

    if (!covered) begin
      dir = lsdp_pkg::DIR_ERROR;
    end else if (!fh) begin
      dir = lsdp_pkg::DIR_FORWARD;
    end else if (!lh && !rh) begin
      dir = (rs > ls) ? lsdp_pkg::DIR_RIGHT : lsdp_pkg::DIR_LEFT;  // tie goes left
    end else if (!rh) begin
      dir = lsdp_pkg::DIR_RIGHT;
    end else if (!lh) begin
      dir = lsdp_pkg::DIR_LEFT;
    end else if ((ls > fs) && (ls > rs)) begin
      dir = lsdp_pkg::DIR_LEFT;
    end else if ((rs > fs) && (rs > ls)) begin
      dir = lsdp_pkg::DIR_RIGHT;
    end else begin
      dir = lsdp_pkg::DIR_FORWARD;
    end
  end

  // ---------------- output register ----------------
  logic [lsdp_pkg::DIR_BITS-1:0] out_dir_r;

  assign out_v_nxt = pend_adv ? 1'b1 : (out_chan.ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (pend_adv) begin
      out_dir_r <= dir;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  assign out_chan.valid     = out_v_r;
  assign out_chan.direction = out_dir_r;

endmodule
